/* hw/rtl/tet_pkg.sv */
package tet_pkg;

    localparam int VALUE_WIDTH  = 16;
    localparam int MAX_SET_SIZE = 1024;
    localparam int COUNT_WIDTH  = $clog2(MAX_SET_SIZE + 1);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [COUNT_WIDTH-1:0]        t_count;

    typedef struct packed {
        t_value value;
        logic   last;
    } t_in_item;

    typedef struct packed {
        t_value largest;
        t_count largest_count;
        t_value second_largest;
        t_count second_largest_count;
        logic   second_largest_valid;
        t_value smallest;
        t_count smallest_count;
        t_value second_smallest;
        t_count second_smallest_count;
        logic   second_smallest_valid;
    } t_out_item;

    // running extremes of the current set
    typedef struct packed {
        logic   set_started;
        t_value top_value;
        t_count top_tally;
        t_value runner_value;
        t_count runner_tally;
        logic   runner_present;
        t_value bottom_value;
        t_count bottom_tally;
        t_value near_bottom_value;
        t_count near_bottom_tally;
        logic   near_bottom_present;
    } t_track_state;

endpackage

/* hw/rtl/tet_update.sv */
module tet_update (
    input  tet_pkg::t_track_state i_state,
    input  tet_pkg::t_value       i_value,
    output tet_pkg::t_track_state o_state
);

    // saturating increment
    function automatic tet_pkg::t_count bump(input tet_pkg::t_count t);
        if (t < tet_pkg::COUNT_WIDTH'(tet_pkg::MAX_SET_SIZE)) begin
            return t + tet_pkg::COUNT_WIDTH'(1);
        end
        return tet_pkg::COUNT_WIDTH'(tet_pkg::MAX_SET_SIZE);
    endfunction

    always_comb begin
        o_state = i_state;
        if (!i_state.set_started) begin
            o_state                     = '0;
            o_state.set_started         = 1'b1;
            o_state.top_value           = i_value;
            o_state.top_tally           = tet_pkg::COUNT_WIDTH'(1);
            o_state.bottom_value        = i_value;
            o_state.bottom_tally        = tet_pkg::COUNT_WIDTH'(1);
        end else begin
            // upper pair
            if (i_value > i_state.top_value) begin
                o_state.runner_value    = i_state.top_value;
                o_state.runner_tally    = i_state.top_tally;
                o_state.runner_present  = 1'b1;
                o_state.top_value       = i_value;
                o_state.top_tally       = tet_pkg::COUNT_WIDTH'(1);
            end else if (i_value == i_state.top_value) begin
                o_state.top_tally       = bump(i_state.top_tally);
            end else if (!i_state.runner_present || i_value > i_state.runner_value) begin
                o_state.runner_value    = i_value;
                o_state.runner_tally    = tet_pkg::COUNT_WIDTH'(1);
                o_state.runner_present  = 1'b1;
            end else if (i_value == i_state.runner_value) begin
                o_state.runner_tally    = bump(i_state.runner_tally);
            end

            // lower pair
            if (i_value < i_state.bottom_value) begin
                o_state.near_bottom_value   = i_state.bottom_value;
                o_state.near_bottom_tally   = i_state.bottom_tally;
                o_state.near_bottom_present = 1'b1;
                o_state.bottom_value        = i_value;
                o_state.bottom_tally        = tet_pkg::COUNT_WIDTH'(1);
            end else if (i_value == i_state.bottom_value) begin
                o_state.bottom_tally        = bump(i_state.bottom_tally);
            end else if (!i_state.near_bottom_present ||
                         i_value < i_state.near_bottom_value) begin
                o_state.near_bottom_value   = i_value;
                o_state.near_bottom_tally   = tet_pkg::COUNT_WIDTH'(1);
                o_state.near_bottom_present = 1'b1;
            end else if (i_value == i_state.near_bottom_value) begin
                o_state.near_bottom_tally   = bump(i_state.near_bottom_tally);
            end
        end
    end

endmodule

/* hw/rtl/top_two_extreme_tracker_unit.sv */
// Result: a transaction marked last shows its result on o_out_valid in the cycle after it
// is accepted; other transactions give no result.
// Throughput: one transaction per cycle, set by the combinational compare and registered update of
// the tracking registers; a last item waits only while a result is held and stalled.
// Reset: synchronous, active low; clears the tracking state and the result valid flag.
module top_two_extreme_tracker_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tet_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tet_pkg::t_out_item o_out_data
);

    tet_pkg::t_track_state r_state;
    tet_pkg::t_track_state n_state;
    tet_pkg::t_out_item    r_out;
    tet_pkg::t_out_item    n_out;
    logic                  r_out_valid;
    logic                  in_accept;
    logic                  out_take;

    // Combinational update of the running extremes against the incoming value.
    tet_update u_update (
        .i_state (r_state),
        .i_value (i_in_data.value),
        .o_state (n_state)
    );

    // Only a last item needs the result register, so ordinary items flow
    // through even while a finished result is held downstream.
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = i_in_data.last && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Result built from the state that includes the last item; second places
    // read zero when absent.
    always_comb begin
        n_out.largest               = n_state.top_value;
        n_out.largest_count         = n_state.top_tally;
        n_out.second_largest        = n_state.runner_present ? n_state.runner_value : '0;
        n_out.second_largest_count  = n_state.runner_present ? n_state.runner_tally : '0;
        n_out.second_largest_valid  = n_state.runner_present;
        n_out.smallest              = n_state.bottom_value;
        n_out.smallest_count        = n_state.bottom_tally;
        n_out.second_smallest       = n_state.near_bottom_present ?
                                      n_state.near_bottom_value : '0;
        n_out.second_smallest_count = n_state.near_bottom_present ?
                                      n_state.near_bottom_tally : '0;
        n_out.second_smallest_valid = n_state.near_bottom_present;
    end

    // Tracking state: cleared at the end of each set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            if (i_in_data.last) begin
                r_state <= '0;
            end else begin
                r_state <= n_state;
            end
        end
    end

    // Result register and its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_in_data.last) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in_data.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
